### rtl/raised_cosine_eq_band_add_macros.svh
// assertion helpers for the raised-cosine band pipeline
`ifndef RAISED_COSINE_EQ_BAND_ADD_MACROS_SVH
`define RAISED_COSINE_EQ_BAND_ADD_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RCBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RCBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rcbe_pkg.sv
package rcbe_pkg;

    // default table sizes
    localparam int COS_TABLE_BITS_DEF = 8;
    localparam int LOG_TABLE_BITS_DEF = 8;

    // field widths
    localparam int FREQ_W      = 24;
    localparam int MAG_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int CORNER_W    = 17;
    localparam int WIDTH_W     = 16;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // internal formats
    localparam int LOG_FRAC_BITS = 12;
    localparam int LOG_BIAS      = 8;
    localparam int LOG2_W        = 21;
    localparam int SPAN_W        = 17;
    localparam int WEIGHT_W      = 31;
    localparam int PROD_W        = GAIN_W + WEIGHT_W;
    localparam int Q30_SHIFT     = 30;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    // register reset values
    localparam logic [CORNER_W-1:0] CORNER_LO_RST = 17'd40960;
    localparam logic [CORNER_W-1:0] CORNER_HI_RST = 17'd49152;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST     = 16'd4096;

    typedef enum logic [1:0] {
        BAND_HIGH_SHELF = 2'd0,
        BAND_LOW_SHELF  = 2'd1,
        BAND_PEAK       = 2'd2,
        BAND_MESA       = 2'd3
    } band_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_TYPE      = 3'd0,
        CFG_GAIN_DB        = 3'd1,
        CFG_CORNER_LO_LOG2 = 3'd2,
        CFG_CORNER_HI_LOG2 = 3'd3,
        CFG_TRANS_LO       = 3'd4,
        CFG_TRANS_HI       = 3'd5
    } cfg_idx_t;

    // how the band weight is chosen for a point
    typedef enum logic [1:0] {
        W_ZERO  = 2'd0,
        W_FULL  = 2'd1,
        W_TRANS = 2'd2
    } wsel_t;

    typedef struct packed {
        band_type_t                band_type;
        logic signed [GAIN_W-1:0]  gain_db;
        logic [CORNER_W-1:0]       corner_lo_log2;
        logic [CORNER_W-1:0]       corner_hi_log2;
        logic [WIDTH_W-1:0]        trans_lo;
        logic [WIDTH_W-1:0]        trans_hi;
    } cfg_t;

    // data that rides along with each point
    typedef struct packed {
        logic signed [MAG_W-1:0] mag;
        logic                    last;
    } side_t;

    // fractional log2 of 1 + idx/2^ltb by repeated squaring
    function automatic logic [LOG_FRAC_BITS-1:0] log_frac(int idx, int ltb);
        longint unsigned m;
        logic [LOG_FRAC_BITS-1:0] r;
        m = (64'd1 << ltb) + longint'(idx);
        m = m << (30 - ltb);
        r = '0;
        for (int k = 0; k < LOG_FRAC_BITS; k++)
        begin
            m = (m * m) >> 30;
            r = {r[LOG_FRAC_BITS-2:0], 1'b0};
            if (m >= (64'd1 << 31))
            begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // cos^2 weight in Q30 for step j of 2^ctb over a quarter turn
    function automatic logic [WEIGHT_W-1:0] rc_weight(int j, int ctb);
        longint x;
        longint x2;
        longint c;
        x  = (Q30_HALF_PI * longint'(j)) >>> ctb;
        x2 = (x * x) >>> 30;
        c  = 2;
        c  = 296 - ((c * x2) >>> 30);
        c  = 26631 - ((c * x2) >>> 30);
        c  = 1491308 - ((c * x2) >>> 30);
        c  = 44739243 - ((c * x2) >>> 30);
        c  = 536870912 - ((c * x2) >>> 30);
        c  = Q30_ONE - ((c * x2) >>> 30);
        if (c < 0)
        begin
            c = 0;
        end
        return WEIGHT_W'((c * c) >>> 30);
    endfunction

endpackage

### rtl/rcbe_log2.sv
module rcbe_log2 #(
    parameter int LOG_TABLE_BITS = rcbe_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [rcbe_pkg::FREQ_W-1:0]       freq,
    input  rcbe_pkg::side_t                   side_in,
    output logic signed [rcbe_pkg::LOG2_W-1:0] l2,
    output logic                              zero,
    output rcbe_pkg::side_t                   side_out
);
    import rcbe_pkg::*;

    localparam int TAB_N = 2 ** LOG_TABLE_BITS;

    logic [4:0]                p_next, p_reg;
    logic [4:0]                shamt;
    logic [FREQ_W-1:0]         norm;
    logic [LOG_TABLE_BITS-1:0] idx_next, idx_reg;
    logic                      zero_next, zero1_reg, zero2_reg;
    side_t                     side1_reg, side2_reg;
    logic [LOG_FRAC_BITS-1:0]  log_tab [TAB_N];
    logic [LOG_FRAC_BITS-1:0]  frac;
    logic signed [LOG2_W-1:0]  l2_next, l2_reg;

    // mantissa table built at elaboration
    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_log_tab
        assign log_tab[gi] = log_frac(gi, LOG_TABLE_BITS);
    end

    // leading one and mantissa bits below it
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < FREQ_W; i++) begin
            if (freq[i]) begin
                p_next = 5'(i);
            end
        end
        shamt     = 5'(FREQ_W - 1) - p_next;
        norm      = freq << shamt;
        idx_next  = norm[FREQ_W-2 -: LOG_TABLE_BITS];
        zero_next = (freq == '0);
    end

    // doubled log2: ((p - bias) << 13) + 2 * frac
    always_comb
    begin
        frac    = log_tab[idx_reg];
        l2_next = ((LOG2_W'(p_reg) - LOG2_W'(LOG_BIAS)) <<< (LOG_FRAC_BITS + 1))
                  + LOG2_W'({frac, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            idx_reg   <= idx_next;
            zero1_reg <= zero_next;
            side1_reg <= side_in;
            l2_reg    <= l2_next;
            zero2_reg <= zero1_reg;
            side2_reg <= side1_reg;
        end
    end

    assign l2       = l2_reg;
    assign zero     = zero2_reg;
    assign side_out = side2_reg;

endmodule

### rtl/rcbe_region.sv
module rcbe_region (
    input  logic                               clk,
    input  logic                               en,
    input  rcbe_pkg::cfg_t                     cfg,
    input  logic signed [rcbe_pkg::LOG2_W-1:0] l2,
    input  logic                               zero,
    input  rcbe_pkg::side_t                    side_in,
    output logic [rcbe_pkg::SPAN_W-1:0]        offs,
    output logic [rcbe_pkg::SPAN_W-1:0]        span,
    output rcbe_pkg::wsel_t                    wsel,
    output rcbe_pkg::side_t                    side_out
);
    import rcbe_pkg::*;

    logic signed [LOG2_W-1:0] c2, h2, wl, wh;
    logic signed [LOG2_W-1:0] c2_next, c2_reg;
    logic signed [LOG2_W-1:0] lo_m_next, lo_m_reg, lo_p_next, lo_p_reg;
    logic signed [LOG2_W-1:0] pk_m_next, pk_m_reg, pk_p_next, pk_p_reg;
    logic signed [LOG2_W-1:0] hi_m_next, hi_m_reg, hi_p_next, hi_p_reg;
    logic [SPAN_W-1:0]        span_lo_next, span_lo_reg, span_hi_next, span_hi_reg;
    logic signed [LOG2_W-1:0] base, d, a;
    logic                     use_hi;
    wsel_t                    wsel_next, wsel_reg;
    logic [SPAN_W-1:0]        offs_next, offs_reg, span_next, span_reg;
    side_t                    side_reg;

    // region bounds from the band settings, doubled scale
    always_comb
    begin
        c2           = LOG2_W'({cfg.corner_lo_log2, 1'b0});
        h2           = LOG2_W'({cfg.corner_hi_log2, 1'b0});
        wl           = LOG2_W'(cfg.trans_lo);
        wh           = LOG2_W'(cfg.trans_hi);
        c2_next      = c2;
        lo_m_next    = c2 - wl;
        lo_p_next    = c2 + wl;
        pk_m_next    = c2 - (wl <<< 1);
        pk_p_next    = c2 + (wl <<< 1);
        hi_m_next    = h2 - wh;
        hi_p_next    = h2 + wh;
        span_lo_next = {cfg.trans_lo, 1'b0};
        span_hi_next = {cfg.trans_hi, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        c2_reg      <= c2_next;
        lo_m_reg    <= lo_m_next;
        lo_p_reg    <= lo_p_next;
        pk_m_reg    <= pk_m_next;
        pk_p_reg    <= pk_p_next;
        hi_m_reg    <= hi_m_next;
        hi_p_reg    <= hi_p_next;
        span_lo_reg <= span_lo_next;
        span_hi_reg <= span_hi_next;
    end

    // pick region, transition origin and span
    always_comb
    begin
        wsel_next = W_ZERO;
        base      = lo_p_reg;
        use_hi    = 1'b0;
        unique case (cfg.band_type)
            BAND_HIGH_SHELF:
            begin
                if (!zero && l2 > lo_m_reg)
                begin
                    wsel_next = (l2 < lo_p_reg) ? W_TRANS : W_FULL;
                end
            end
            BAND_LOW_SHELF:
            begin
                if (zero || l2 < lo_m_reg)
                begin
                    wsel_next = W_FULL;
                end
                else if (l2 < lo_p_reg)
                begin
                    wsel_next = W_TRANS;
                    base      = lo_m_reg;
                end
            end
            BAND_PEAK:
            begin
                if (!zero && l2 > pk_m_reg && l2 < pk_p_reg)
                begin
                    wsel_next = W_TRANS;
                    base      = c2_reg;
                end
            end
            BAND_MESA:
            begin
                if (!zero && l2 > lo_m_reg)
                begin
                    if (l2 < lo_p_reg)
                    begin
                        wsel_next = W_TRANS;
                    end
                    else if (l2 < hi_m_reg)
                    begin
                        wsel_next = W_FULL;
                    end
                    else if (l2 < hi_p_reg)
                    begin
                        wsel_next = W_TRANS;
                        base      = hi_m_reg;
                        use_hi    = 1'b1;
                    end
                end
            end
        endcase
        d         = l2 - base;
        a         = (d < 0) ? -d : d;
        offs_next = a[SPAN_W-1:0];
        span_next = use_hi ? span_hi_reg : span_lo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wsel_reg <= wsel_next;
            offs_reg <= offs_next;
            span_reg <= span_next;
            side_reg <= side_in;
        end
    end

    assign offs     = offs_reg;
    assign span     = span_reg;
    assign wsel     = wsel_reg;
    assign side_out = side_reg;

endmodule

### rtl/rcbe_div.sv
module rcbe_div #(
    parameter int COS_TABLE_BITS = rcbe_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rcbe_pkg::SPAN_W-1:0] offs,
    input  logic [rcbe_pkg::SPAN_W-1:0] span,
    input  rcbe_pkg::wsel_t             wsel_in,
    input  rcbe_pkg::side_t             side_in,
    output logic [COS_TABLE_BITS-1:0]   quot,
    output rcbe_pkg::wsel_t             wsel_out,
    output rcbe_pkg::side_t             side_out
);
    import rcbe_pkg::*;

    localparam int NS = COS_TABLE_BITS;

    logic [SPAN_W-1:0] rem_reg  [NS];
    logic [SPAN_W-1:0] span_reg [NS];
    logic [NS-1:0]     q_reg    [NS];
    wsel_t             wsel_reg [NS];
    side_t             side_reg [NS];

    // restoring divide, one quotient bit per stage; offset < span for every transition point
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [SPAN_W-1:0] rem_in, span_in, rem_next;
        logic [NS-1:0]     q_in, q_next;
        wsel_t             wsel_src;
        side_t             side_src;
        logic [SPAN_W:0]   r2, diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in   = offs;
            assign span_in  = span;
            assign q_in     = '0;
            assign wsel_src = wsel_in;
            assign side_src = side_in;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign span_in  = span_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign wsel_src = wsel_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb
        begin
            r2       = {rem_in, 1'b0};
            diff     = r2 - {1'b0, span_in};
            ge       = (r2 >= {1'b0, span_in});
            rem_next = ge ? diff[SPAN_W-1:0] : r2[SPAN_W-1:0];
            q_next   = {q_in[NS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                span_reg[k] <= span_in;
                q_reg[k]    <= q_next;
                wsel_reg[k] <= wsel_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign quot     = q_reg[NS-1];
    assign wsel_out = wsel_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

### rtl/rcbe_gain.sv
module rcbe_gain #(
    parameter int COS_TABLE_BITS = rcbe_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [rcbe_pkg::GAIN_W-1:0] gain_db,
    input  logic [COS_TABLE_BITS-1:0]          quot,
    input  rcbe_pkg::wsel_t                    wsel,
    input  rcbe_pkg::side_t                    side_in,
    output logic [rcbe_pkg::MAG_W-1:0]         mag_out,
    output logic                               clipped,
    output logic                               last_out
);
    import rcbe_pkg::*;

    localparam int TAB_N = 2 ** COS_TABLE_BITS;
    localparam int SUM_W = MAG_W + 2;
    localparam int RND_W = PROD_W - Q30_SHIFT;

    logic [WEIGHT_W-1:0]      cos_tab [TAB_N];
    logic [WEIGHT_W-1:0]      w_rom_next, w_rom_reg, w;
    wsel_t                    wsel_reg;
    side_t                    side1_reg, side2_reg;
    logic [GAIN_W:0]          g_ext;
    logic [GAIN_W-1:0]        g_abs;
    logic [PROD_W-1:0]        prod_next, prod_reg, rnd;
    logic                     neg_next, neg_reg;
    logic [RND_W-1:0]         r;
    logic signed [SUM_W-1:0]  delta, sum;
    logic [MAG_W-1:0]         mag_next, mag_reg;
    logic                     clip_next, clip_reg, last_reg;

    // weight table built at elaboration
    for (genvar gi = 0; gi < TAB_N; gi++)
    begin : g_cos_tab
        assign cos_tab[gi] = rc_weight(gi, COS_TABLE_BITS);
    end

    // table read
    assign w_rom_next = cos_tab[quot];

    // weight select and gain multiply
    always_comb
    begin
        unique case (wsel_reg)
            W_ZERO:  w = '0;
            W_FULL:  w = WEIGHT_W'(Q30_ONE);
            W_TRANS: w = w_rom_reg;
            default: w = '0;
        endcase
        g_ext     = gain_db[GAIN_W-1] ? -{gain_db[GAIN_W-1], gain_db}
                                      : {1'b0, gain_db};
        g_abs     = g_ext[GAIN_W-1:0];
        prod_next = PROD_W'(g_abs) * PROD_W'(w);
        neg_next  = gain_db[GAIN_W-1];
    end

    // round half away from zero, add and saturate
    always_comb
    begin
        rnd   = prod_reg + (PROD_W'(1) << (Q30_SHIFT - 1));
        r     = rnd[PROD_W-1:Q30_SHIFT];
        delta = neg_reg ? -SUM_W'(r) : SUM_W'(r);
        sum   = SUM_W'(side2_reg.mag) + delta;
        if (sum > SUM_W'(32767))
        begin
            mag_next  = 16'h7FFF;
            clip_next = 1'b1;
        end
        else if (sum < -SUM_W'(32768))
        begin
            mag_next  = 16'h8000;
            clip_next = 1'b1;
        end
        else
        begin
            mag_next  = sum[MAG_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_rom_reg <= w_rom_next;
            wsel_reg  <= wsel;
            side1_reg <= side_in;
            prod_reg  <= prod_next;
            neg_reg   <= neg_next;
            side2_reg <= side1_reg;
            mag_reg   <= mag_next;
            clip_reg  <= clip_next;
            last_reg  <= side2_reg.last;
        end
    end

    assign mag_out  = mag_reg;
    assign clipped  = clip_reg;
    assign last_out = last_reg;

endmodule

### rtl/raised_cosine_eq_band_add.sv
// a point passes the log2, region, divider and gain stages in turn from input request to result
// throughput: one point per cycle while no finished result is held; the divider gives one quotient bit per stage
// the whole pipeline holds while a finished result is not taken
// reset: valid bits cleared, band registers to their defaults; data regs not reset
`include "raised_cosine_eq_band_add_macros.svh"

module raised_cosine_eq_band_add #(
    parameter int COS_TABLE_BITS = rcbe_pkg::COS_TABLE_BITS_DEF,
    parameter int LOG_TABLE_BITS = rcbe_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rcbe_pkg::IN_TDATA_W-1:0]     s_tdata,   // freq_hz, mag_db_in
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rcbe_pkg::OUT_TDATA_W-1:0]    m_tdata,   // mag_db_out
    output logic                                m_tuser,   // clipped
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [rcbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcbe_pkg::CFG_W-1:0]          cfg_data
);
    import rcbe_pkg::*;

    localparam int LAT = COS_TABLE_BITS + 6;

    cfg_t                     cfg_next, cfg_reg;
    logic [LAT-1:0]           valid_next, valid_reg;
    logic                     en;
    side_t                    side_in, side_l, side_r, side_d;
    logic signed [LOG2_W-1:0] l2;
    logic                     zero;
    logic [SPAN_W-1:0]        offs, span;
    wsel_t                    wsel_r, wsel_d;
    logic [COS_TABLE_BITS-1:0] quot;

    // band registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BAND_TYPE:      cfg_next.band_type      = band_type_t'(cfg_data[1:0]);
                CFG_GAIN_DB:        cfg_next.gain_db        = cfg_data[GAIN_W-1:0];
                CFG_CORNER_LO_LOG2: cfg_next.corner_lo_log2 = cfg_data[CORNER_W-1:0];
                CFG_CORNER_HI_LOG2: cfg_next.corner_hi_log2 = cfg_data[CORNER_W-1:0];
                CFG_TRANS_LO:       cfg_next.trans_lo       = cfg_data[WIDTH_W-1:0];
                CFG_TRANS_HI:       cfg_next.trans_hi       = cfg_data[WIDTH_W-1:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_type      <= BAND_HIGH_SHELF;
            cfg_reg.gain_db        <= '0;
            cfg_reg.corner_lo_log2 <= CORNER_LO_RST;
            cfg_reg.corner_hi_log2 <= CORNER_HI_RST;
            cfg_reg.trans_lo       <= WIDTH_RST;
            cfg_reg.trans_hi       <= WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline advance and valid bits
    assign en         = !valid_reg[LAT-1] || m_tready;
    assign s_tready   = en;
    assign valid_next = {valid_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign side_in.mag  = s_tdata[FREQ_W +: MAG_W];
    assign side_in.last = s_tlast;

    rcbe_log2 #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log2 (
        .clk      (clk),
        .en       (en),
        .freq     (s_tdata[FREQ_W-1:0]),
        .side_in  (side_in),
        .l2       (l2),
        .zero     (zero),
        .side_out (side_l)
    );

    rcbe_region u_region (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .l2       (l2),
        .zero     (zero),
        .side_in  (side_l),
        .offs     (offs),
        .span     (span),
        .wsel     (wsel_r),
        .side_out (side_r)
    );

    rcbe_div #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_div (
        .clk      (clk),
        .en       (en),
        .offs     (offs),
        .span     (span),
        .wsel_in  (wsel_r),
        .side_in  (side_r),
        .quot     (quot),
        .wsel_out (wsel_d),
        .side_out (side_d)
    );

    rcbe_gain #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_gain (
        .clk      (clk),
        .en       (en),
        .gain_db  (cfg_reg.gain_db),
        .quot     (quot),
        .wsel     (wsel_d),
        .side_in  (side_d),
        .mag_out  (m_tdata),
        .clipped  (m_tuser),
        .last_out (m_tlast)
    );

    assign m_tvalid = valid_reg[LAT-1];

    // checks
    `RCBE_ASSERT_NOW(a_clip_is_rail, m_tvalid && m_tuser, m_tdata == 16'h7FFF || m_tdata == 16'h8000, "clip off rail")
    `RCBE_ASSERT_NOW(a_stall_only_full, !s_tready, m_tvalid && !m_tready, "input held off with room")
    `RCBE_ASSERT_NEXT(a_request_enters, s_tvalid && s_tready, valid_reg[0], "request not in first stage")

endmodule
